FILE: rtl/fsgr_pkg.sv
// ----------------------------------------------------------------------------
// Falling-sand grid engine package
// Shared payload types, opcodes, direction codes and controller states.
// ----------------------------------------------------------------------------
package fsgr_pkg;

  // Opcodes of an input item.
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Candidate directions tried for a falling grain, in priority order.
  localparam logic [1:0] DIR_DOWN  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  cell_x;
    logic [6:0]  cell_y;
    logic [31:0] grain_color;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] moved_count;
    logic        occupied;
    logic [31:0] pixel_color;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_CHK,
    S_RD_CHK,
    S_T_POS,
    S_T_LATCH,
    S_T_CAND,
    S_T_CHK,
    S_T_SRC,
    S_T_MV1,
    S_T_MV2,
    S_T_NEXT,
    S_RESP
  } state_e;

endpackage

FILE: rtl/falling_sand_grid_engine.sv
// ----------------------------------------------------------------------------
// Falling-sand grid engine
// Grid of colored grains with add, tick and read commands.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                  Payload
//  in       input      in_valid_i / in_stall_o    in_item_i  (in_item_t)
//  out      output     out_valid_o / out_stall_i  out_item_o (out_item_t)
//  cfg      input      cfg_we_i                   cfg_wdata_i (background color)
//
// Add and read each check the cell through the registered cell memory read.
// A tick handles each grain in turn through the position read, up to three
// candidate cell reads and, when a free target is found, the two move writes.
// After reset a clearing pass empties every address of the cell memory; no
// item is taken during it. A stalled result holds in the output register; the
// next item is taken once the result is loaded there.
module falling_sand_grid_engine
  import fsgr_pkg::*;
#(
  parameter int GRID_WIDTH  = 256,
  parameter int GRID_HEIGHT = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int XW   = $clog2(GRID_WIDTH);
  localparam int YW   = $clog2(GRID_HEIGHT);
  localparam int AW   = XW + YW;
  localparam int CNT  = GRID_WIDTH * GRID_HEIGHT;
  localparam int PAW  = $clog2(CNT);
  localparam int TW   = $clog2(CNT + 1);
  localparam logic [XW:0] WIDTH_L  = (XW + 1)'(GRID_WIDTH);
  localparam logic [YW:0] HEIGHT_L = (YW + 1)'(GRID_HEIGHT);
  localparam logic [TW-1:0] CNT_L  = TW'(CNT);

  state_e state_q, state_d;

  logic [31:0]   bg_q;
  logic [AW-1:0] clr_q;
  in_item_t      item_q;
  logic          inrange_q;
  out_item_t     res_q;
  logic [TW-1:0] total_q;
  logic [TW-1:0] g_q;
  logic [XW-1:0] gx_q, tx_q;
  logic [YW-1:0] gy_q, ty_q;
  logic [1:0]    dir_q;

  // Cell memory ports: bit 32 is the occupied flag.
  logic          cell_we;
  logic [AW-1:0] cell_waddr, cell_raddr;
  logic [32:0]   cell_wdata, cell_rdata;

  // Grain position memory ports: {y, x}.
  logic           pos_we;
  logic [PAW-1:0] pos_waddr, pos_raddr;
  logic [AW-1:0]  pos_wdata, pos_rdata;

  logic in_xfer;
  logic in_grid_in;
  logic add_ok;
  logic last_dir;

  // Candidate target for the current grain and direction.
  logic [YW:0]   ny_w;
  logic [XW:0]   nx_w;
  logic          cand_ok;
  logic [AW-1:0] cand_addr;

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_grid_in = ({24'd0, in_item_i.cell_x} < 32'(GRID_WIDTH)) &&
                      ({25'd0, in_item_i.cell_y} < 32'(GRID_HEIGHT));
  assign add_ok     = inrange_q && !cell_rdata[32] && (total_q < CNT_L);
  assign last_dir   = (dir_q == DIR_LEFT);

  always_comb begin
    ny_w = {1'b0, gy_q} + (YW + 1)'(1);
    case (dir_q)
      DIR_RIGHT: nx_w = {1'b0, gx_q} + (XW + 1)'(1);
      DIR_LEFT:  nx_w = {1'b0, gx_q} - (XW + 1)'(1);
      default:   nx_w = {1'b0, gx_q};
    endcase
    cand_ok = (ny_w < HEIGHT_L) &&
              ((dir_q == DIR_DOWN) ||
               ((dir_q == DIR_RIGHT) && (nx_w < WIDTH_L)) ||
               ((dir_q == DIR_LEFT) && (gx_q != '0)));
    cand_addr = {ny_w[YW-1:0], nx_w[XW-1:0]};
  end

  fsgr_ram #(.WIDTH(33), .DEPTH(2 ** AW)) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  fsgr_ram #(.WIDTH(AW), .DEPTH(CNT)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:   if (clr_q == '1) state_d = S_IDLE;
      S_IDLE: begin
        if (in_xfer) begin
          case (in_item_i.opcode)
            OP_ADD:  state_d = S_ADD_CHK;
            OP_READ: state_d = S_RD_CHK;
            OP_TICK: state_d = (total_q == '0) ? S_RESP : S_T_POS;
            default: state_d = S_RESP;
          endcase
        end
      end
      S_ADD_CHK: state_d = S_RESP;
      S_RD_CHK:  state_d = S_RESP;
      S_T_POS:   state_d = S_T_LATCH;
      S_T_LATCH: state_d = S_T_CAND;
      S_T_CAND: begin
        if (cand_ok) state_d = S_T_CHK;
        else if (last_dir) state_d = S_T_NEXT;
      end
      S_T_CHK: begin
        if (!cell_rdata[32]) state_d = S_T_SRC;
        else if (last_dir) state_d = S_T_NEXT;
        else state_d = S_T_CAND;
      end
      S_T_SRC:   state_d = S_T_MV1;
      S_T_MV1:   state_d = S_T_MV2;
      S_T_MV2:   state_d = S_T_NEXT;
      S_T_NEXT:  state_d = (g_q + TW'(1) == total_q) ? S_RESP : S_T_POS;
      S_RESP:    if (!out_valid_o || !out_stall_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = '0;
    cell_wdata = '0;
    cell_raddr = '0;
    pos_we     = 1'b0;
    pos_waddr  = '0;
    pos_wdata  = '0;
    pos_raddr  = '0;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_q;
      end
      S_IDLE: begin
        cell_raddr = {YW'(in_item_i.cell_y), XW'(in_item_i.cell_x)};
      end
      S_ADD_CHK: begin
        cell_waddr = {YW'(item_q.cell_y), XW'(item_q.cell_x)};
        cell_wdata = {1'b1, item_q.grain_color};
        cell_we    = (item_q.opcode == OP_ADD) && add_ok;
        pos_we     = cell_we;
        pos_waddr  = total_q[PAW-1:0];
        pos_wdata  = cell_waddr;
      end
      S_T_POS:  pos_raddr  = g_q[PAW-1:0];
      S_T_CAND: cell_raddr = cand_addr;
      S_T_SRC:  cell_raddr = {gy_q, gx_q};
      S_T_MV1: begin
        cell_we    = 1'b1;
        cell_waddr = {ty_q, tx_q};
        cell_wdata = {1'b1, cell_rdata[31:0]};
      end
      S_T_MV2: begin
        cell_we    = 1'b1;
        cell_waddr = {gy_q, gx_q};
        pos_we     = 1'b1;
        pos_waddr  = g_q[PAW-1:0];
        pos_wdata  = {ty_q, tx_q};
      end
      default: ;
    endcase
  end

  // Control and data registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      bg_q        <= '0;
      total_q     <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) bg_q <= cfg_wdata_i;
      if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
      if (state_q == S_ADD_CHK && cell_we) total_q <= total_q + TW'(1);
      if (state_q == S_RESP && (!out_valid_o || !out_stall_i)) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q    <= in_item_i;
      inrange_q <= in_grid_in;
      res_q     <= '0;
      g_q       <= '0;
    end
    case (state_q)
      S_ADD_CHK: res_q.accepted <= cell_we;
      S_RD_CHK: begin
        res_q.occupied    <= inrange_q && cell_rdata[32];
        res_q.pixel_color <= (inrange_q && cell_rdata[32]) ? cell_rdata[31:0] : bg_q;
      end
      S_T_LATCH: begin
        gx_q  <= pos_rdata[XW-1:0];
        gy_q  <= pos_rdata[AW-1:XW];
        dir_q <= DIR_DOWN;
      end
      S_T_CAND: if (!cand_ok && !last_dir) dir_q <= dir_q + 2'd1;
      S_T_CHK: begin
        tx_q <= nx_w[XW-1:0];
        ty_q <= ny_w[YW-1:0];
        if (cell_rdata[32] && !last_dir) dir_q <= dir_q + 2'd1;
      end
      // The move count saturates at its field width.
      S_T_MV2: begin
        if (res_q.moved_count != 16'hFFFF) begin
          res_q.moved_count <= res_q.moved_count + 16'd1;
        end
      end
      S_T_NEXT: g_q <= g_q + TW'(1);
      S_RESP: begin
        if (!out_valid_o || !out_stall_i) out_item_o <= res_q;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/fsgr_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fsgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
